@@ sv/maze_dfs_carver_macros.svh @@
// ----------------------------------------------------------------------------
// maze_dfs_carver_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MAZE_DFS_CARVER_MACROS_SVH
`define MAZE_DFS_CARVER_MACROS_SVH

// same-cycle implication
`define MDC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("maze_dfs_carver: same-cycle check failed");

// next-cycle implication
`define MDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("maze_dfs_carver: next-cycle check failed");

`endif

@@ sv/mdc_pkg.sv @@
// ----------------------------------------------------------------------------
// mdc_pkg
// Widths, codes, reset values and types of the maze carver.
// ----------------------------------------------------------------------------
package mdc_pkg;

   localparam int MAX_COLS_DEF = 64;
   localparam int MAX_ROWS_DEF = 64;

   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int COORD_W   = 6;
   localparam int DIR_W     = 2;
   localparam int TRIED_W   = 4;

   localparam logic [CFG_W-1:0] GRID_COLS_RST = 7'd16;
   localparam logic [CFG_W-1:0] GRID_ROWS_RST = 7'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'b1;

   localparam logic FUNC_DRAW    = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

   localparam logic [TRIED_W-1:0] TRIED_ALL = 4'hF;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_CHECK = 4'b0100,
      ST_POP   = 4'b1000
   } state_type;

endpackage

@@ sv/mdc_ram.sv @@
// ----------------------------------------------------------------------------
// mdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mdc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/maze_dfs_carver.sv @@
// ----------------------------------------------------------------------------
// maze_dfs_carver
// Randomised depth-first maze carver: visited map and cell stack in RAM,
// current cell in registers, one neighbour adder/compare under a sequencer.
// ----------------------------------------------------------------------------
//  channel  ports                         handshake
//  req      req_func, req_rand_dir        start & !busy
//  rsp      rsp_carved .. rsp_finished    rsp_strobe, one cycle
//  csr      csr_index, csr_wdata          csr_valid & csr_ready
//
//  A draw is a neighbour map read, then a map/stack write; a pop that
//  leaves cells on the stack adds a stack read (ST_POP) after it.
//  A draw after finish and a restart answer in the next cycle; a restart
//  then runs a clearing pass over all 2**(clog2(MAX_COLS)+clog2(MAX_ROWS))
//  map addresses (4096 by default), as does reset. busy is high meanwhile;
//  csr writes are always taken. Results cannot be stalled.
// ----------------------------------------------------------------------------
module maze_dfs_carver #(
   parameter int MAX_COLS = mdc_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = mdc_pkg::MAX_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_func,
   input  logic [mdc_pkg::DIR_W-1:0]       req_rand_dir,
   output logic                            rsp_strobe,
   output logic                            rsp_carved,
   output logic [mdc_pkg::COORD_W-1:0]     rsp_cell_x,
   output logic [mdc_pkg::COORD_W-1:0]     rsp_cell_y,
   output logic [mdc_pkg::DIR_W-1:0]       rsp_wall_dir,
   output logic                            rsp_backtracked,
   output logic                            rsp_finished,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mdc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mdc_pkg::CFG_W-1:0]       csr_wdata
);

   import mdc_pkg::*;

   localparam int XW     = $clog2(MAX_COLS);
   localparam int YW     = $clog2(MAX_ROWS);
   localparam int CW     = (XW > YW) ? XW : YW;
   localparam int SW     = CW + 1;
   localparam int KW     = (SW > CFG_W) ? SW : CFG_W;
   localparam int VAW    = XW + YW;
   localparam int VDEPTH = 1 << VAW;
   localparam int CELLS  = MAX_COLS * MAX_ROWS;
   localparam int SAW    = $clog2(CELLS);
   localparam int DW     = $clog2(CELLS + 1);

   state_type state_ff, state_in;
   logic [VAW-1:0]     clr_ff, clr_in;
   logic [XW-1:0]      cur_x_ff, cur_x_in, nb_x_ff, nb_x_in;
   logic [YW-1:0]      cur_y_ff, cur_y_in, nb_y_ff, nb_y_in;
   logic               inb_ff, inb_in;
   logic [DIR_W-1:0]   dir_ff, dir_in;
   logic [TRIED_W-1:0] tried_ff, tried_in, tried_new;
   logic [DW-1:0]      depth_ff, depth_in, depth_m2;
   logic               done_ff, done_in;
   logic [CFG_W-1:0]   grid_cols_ff, grid_rows_ff;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_carved_ff, rsp_carved_in;
   logic [XW-1:0]      rsp_x_ff, rsp_x_in;
   logic [YW-1:0]      rsp_y_ff, rsp_y_in;
   logic [DIR_W-1:0]   rsp_dir_ff, rsp_dir_in;
   logic               rsp_back_ff, rsp_back_in;
   logic               rsp_fin_ff, rsp_fin_in;

   logic [KW-1:0] cols_k, rows_k, cols_eff, rows_eff;
   logic [SW-1:0] base, limit, sum, side, side_limit;
   logic          axis_y, dec, inb;
   logic [XW-1:0] nb_x;
   logic [YW-1:0] nb_y;

   logic           vis_we, vis_wdata, vis_rdata;
   logic [VAW-1:0] vis_waddr;
   logic           stk_we;
   logic [SAW-1:0] stk_waddr;
   logic [VAW-1:0] stk_wdata, stk_rdata;
   logic           accept, push;

   // clamp grid size to 1..MAX
   always_comb begin
      cols_k = KW'(grid_cols_ff);
      rows_k = KW'(grid_rows_ff);
      if (cols_k == '0) begin
         cols_eff = KW'(1);
      end else if (cols_k > KW'(MAX_COLS)) begin
         cols_eff = KW'(MAX_COLS);
      end else begin
         cols_eff = cols_k;
      end
      if (rows_k == '0) begin
         rows_eff = KW'(1);
      end else if (rows_k > KW'(MAX_ROWS)) begin
         rows_eff = KW'(MAX_ROWS);
      end else begin
         rows_eff = rows_k;
      end
   end

   // shared neighbour unit: one step on one axis, then bounds compare
   always_comb begin
      axis_y = 1'b0;
      dec    = 1'b0;
      case (req_rand_dir)
         DIR_DOWN: begin
            axis_y = 1'b1;
            dec    = 1'b0;
         end
         DIR_RIGHT: begin
            axis_y = 1'b0;
            dec    = 1'b0;
         end
         DIR_UP: begin
            axis_y = 1'b1;
            dec    = 1'b1;
         end
         DIR_LEFT: begin
            axis_y = 1'b0;
            dec    = 1'b1;
         end
         default: begin
            axis_y = 1'b0;
            dec    = 1'b0;
         end
      endcase
      base       = axis_y ? SW'(cur_y_ff) : SW'(cur_x_ff);
      limit      = axis_y ? SW'(rows_eff) : SW'(cols_eff);
      side       = axis_y ? SW'(cur_x_ff) : SW'(cur_y_ff);
      side_limit = axis_y ? SW'(cols_eff) : SW'(rows_eff);
      sum        = dec ? (base - SW'(1)) : (base + SW'(1));
      // a step below zero wraps to all ones, which is never below the limit
      inb        = (sum < limit) && (side < side_limit);
      nb_x       = axis_y ? cur_x_ff : sum[XW-1:0];
      nb_y       = axis_y ? sum[YW-1:0] : cur_y_ff;
   end

   assign accept    = start && (state_ff == ST_IDLE);
   assign push      = inb_ff && !vis_rdata;
   assign tried_new = tried_ff | (TRIED_W'(1) << dir_ff);
   assign depth_m2  = depth_ff - DW'(2);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      nb_x_in       = nb_x_ff;
      nb_y_in       = nb_y_ff;
      inb_in        = inb_ff;
      dir_in        = dir_ff;
      tried_in      = tried_ff;
      depth_in      = depth_ff;
      done_in       = done_ff;
      rsp_strobe_in = 1'b0;
      rsp_carved_in = 1'b0;
      rsp_x_in      = '0;
      rsp_y_in      = '0;
      rsp_dir_in    = '0;
      rsp_back_in   = 1'b0;
      rsp_fin_in    = 1'b0;
      vis_we        = 1'b0;
      vis_waddr     = {nb_y_ff, nb_x_ff};
      vis_wdata     = 1'b1;
      stk_we        = 1'b0;
      stk_waddr     = depth_ff[SAW-1:0];
      stk_wdata     = {nb_y_ff, nb_x_ff};

      unique case (state_ff)
         ST_CLEAR: begin
            vis_we    = 1'b1;
            vis_waddr = clr_ff;
            vis_wdata = (clr_ff == '0);
            stk_we    = (clr_ff == '0);
            stk_waddr = '0;
            stk_wdata = '0;
            clr_in    = clr_ff + VAW'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_RESTART) begin
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_CLEAR;
                  clr_in        = '0;
                  cur_x_in      = '0;
                  cur_y_in      = '0;
                  tried_in      = '0;
                  depth_in      = DW'(1);
                  done_in       = 1'b0;
               end else if (done_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_fin_in    = 1'b1;
               end else begin
                  nb_x_in  = nb_x;
                  nb_y_in  = nb_y;
                  inb_in   = inb;
                  dir_in   = req_rand_dir;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            rsp_strobe_in = 1'b1;
            rsp_x_in      = cur_x_ff;
            rsp_y_in      = cur_y_ff;
            state_in      = ST_IDLE;
            if (push) begin
               vis_we        = 1'b1;
               stk_we        = 1'b1;
               depth_in      = depth_ff + DW'(1);
               cur_x_in      = nb_x_ff;
               cur_y_in      = nb_y_ff;
               tried_in      = '0;
               rsp_carved_in = 1'b1;
               rsp_dir_in    = dir_ff;
            end else if (tried_new == TRIED_ALL) begin
               depth_in    = depth_ff - DW'(1);
               tried_in    = '0;
               rsp_back_in = 1'b1;
               if (depth_ff == DW'(1)) begin
                  done_in    = 1'b1;
                  rsp_fin_in = 1'b1;
               end else begin
                  state_in = ST_POP;
               end
            end else begin
               tried_in = tried_new;
            end
         end
         ST_POP: begin
            cur_x_in = stk_rdata[XW-1:0];
            cur_y_in = stk_rdata[VAW-1:XW];
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         tried_ff      <= '0;
         depth_ff      <= DW'(1);
         done_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         grid_cols_ff  <= GRID_COLS_RST;
         grid_rows_ff  <= GRID_ROWS_RST;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         tried_ff      <= tried_in;
         depth_ff      <= depth_in;
         done_ff       <= done_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_GRID_COLS: grid_cols_ff <= csr_wdata;
               CSR_GRID_ROWS: grid_rows_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      nb_x_ff       <= nb_x_in;
      nb_y_ff       <= nb_y_in;
      inb_ff        <= inb_in;
      dir_ff        <= dir_in;
      rsp_carved_ff <= rsp_carved_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   mdc_ram #(
      .WIDTH (1),
      .DEPTH (VDEPTH)
   ) u_visited (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_waddr),
      .wr_data (vis_wdata),
      .rd_addr ({nb_y, nb_x}),
      .rd_data (vis_rdata)
   );

   mdc_ram #(
      .WIDTH (VAW),
      .DEPTH (CELLS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (depth_m2[SAW-1:0]),
      .rd_data (stk_rdata)
   );

   assign busy            = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_carved      = rsp_carved_ff;
   assign rsp_cell_x      = COORD_W'(rsp_x_ff);
   assign rsp_cell_y      = COORD_W'(rsp_y_ff);
   assign rsp_wall_dir    = rsp_dir_ff;
   assign rsp_backtracked = rsp_back_ff;
   assign rsp_finished    = rsp_fin_ff;

endmodule

@@ sv/mdc_checker.sv @@
// ----------------------------------------------------------------------------
// mdc_checker
// Port-level checks on the maze carver, bound to the top level.
// ----------------------------------------------------------------------------
`include "maze_dfs_carver_macros.svh"

module mdc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            req_func,
   input logic                            rsp_strobe,
   input logic                            rsp_carved,
   input logic [mdc_pkg::COORD_W-1:0]     rsp_cell_x,
   input logic [mdc_pkg::COORD_W-1:0]     rsp_cell_y,
   input logic [mdc_pkg::DIR_W-1:0]       rsp_wall_dir,
   input logic                            rsp_backtracked,
   input logic                            rsp_finished
);

   import mdc_pkg::*;

   logic restart_acc;
   logic carve_word;
   logic fin_only;

   assign restart_acc = start && !busy && (req_func == FUNC_RESTART);
   assign carve_word  = rsp_strobe && rsp_carved;
   assign fin_only    = rsp_strobe && rsp_finished && !rsp_backtracked;

   // restart answers next cycle with busy high as the clearing pass starts
   `MDC_ASSERT_NEXT(a_restart_word, clock, reset, restart_acc, rsp_strobe && busy)
   // a carve is never a pop or a finish
   `MDC_ASSERT_SAME(a_carve_excl, clock, reset, carve_word, !rsp_backtracked && !rsp_finished)
   // wall side only reported with a carve
   `MDC_ASSERT_SAME(a_wall_zero, clock, reset, rsp_strobe && !rsp_carved, rsp_wall_dir == '0)
   // draw after finish names no cell
   `MDC_ASSERT_SAME(a_fin_blank, clock, reset, fin_only,
      !rsp_carved && (rsp_cell_x == '0) && (rsp_cell_y == '0))

endmodule

bind maze_dfs_carver mdc_checker u_mdc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_func        (req_func),
   .rsp_strobe      (rsp_strobe),
   .rsp_carved      (rsp_carved),
   .rsp_cell_x      (rsp_cell_x),
   .rsp_cell_y      (rsp_cell_y),
   .rsp_wall_dir    (rsp_wall_dir),
   .rsp_backtracked (rsp_backtracked),
   .rsp_finished    (rsp_finished)
);
